// ----- rtl/core/direction_sample_mapper_unit_assert.svh -----
// ---------------------------------------------------------------------------
// assertion macros for the direction sample mapper
// concurrent checks on clk, held off while rst_n is low
// ---------------------------------------------------------------------------
`ifndef DIRECTION_SAMPLE_MAPPER_UNIT_ASSERT_SVH
`define DIRECTION_SAMPLE_MAPPER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// property checked at every rising clock edge outside reset
`define DSMU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication checked at every rising clock edge outside reset
`define DSMU_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`else
`define DSMU_ASSERT(label, prop, msg)
`define DSMU_ASSERT_IMP(label, pre, post, msg)
`endif

`endif

// ----- rtl/core/dsmu_pkg.sv -----
// ---------------------------------------------------------------------------
// dsmu_pkg
// shared constants, codes, the cordic arctangent table and the cell control
// ---------------------------------------------------------------------------
package dsmu_pkg;

    // default parameter values
    localparam int FRACTION_BITS_DEF    = 16;
    localparam int ANGLE_ITERATIONS_DEF = 16;

    // port formats
    localparam int IN_W   = 16;
    localparam int FUNC_W = 3;
    localparam int OUT_W  = 18;

    // cordic word and gain (q30)
    localparam int CW = 32;
    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;

    // mapping codes
    localparam logic [FUNC_W-1:0] FUNC_HEMI   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SPHERE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_DISK   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_COSINE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CONE   = 3'd4;

    // advance and valid handed to every cell
    typedef struct packed {
        logic en;
        logic vld;
    } step_t;

    // arctangent of 2^-i in binary turns, 2^32 a full turn
    function automatic logic [CW-1:0] atan_turns(input int idx);
        logic [CW-1:0] val;
        unique case (idx)
            0:  val = 32'h20000000;
            1:  val = 32'h12E4051D;
            2:  val = 32'h09FB385B;
            3:  val = 32'h051111D4;
            4:  val = 32'h028B0D43;
            5:  val = 32'h0145D7E1;
            6:  val = 32'h00A2F61E;
            7:  val = 32'h00517C55;
            8:  val = 32'h0028BE53;
            9:  val = 32'h00145F2F;
            10: val = 32'h000A2F98;
            11: val = 32'h000517CC;
            12: val = 32'h00028BE6;
            13: val = 32'h000145F3;
            14: val = 32'h0000A2F9;
            15: val = 32'h0000517C;
            16: val = 32'h000028BE;
            17: val = 32'h0000145F;
            18: val = 32'h00000A2F;
            19: val = 32'h00000517;
            20: val = 32'h0000028B;
            21: val = 32'h00000145;
            22: val = 32'h000000A2;
            23: val = 32'h00000051;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ----- rtl/core/dsmu_sample_if.sv -----
// ---------------------------------------------------------------------------
// dsmu_sample_if
// input channel: mapping code, two uniform numbers and the cone limit
// ---------------------------------------------------------------------------
interface dsmu_sample_if
    import dsmu_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [FUNC_W-1:0]       func;
    logic [IN_W-1:0]         first_uniform;
    logic [IN_W-1:0]         second_uniform;
    logic signed [OUT_W-1:0] cone_cos_limit;

    modport source (
        output valid, func, first_uniform, second_uniform, cone_cos_limit,
        input  ready
    );

    modport sink (
        input  valid, func, first_uniform, second_uniform, cone_cos_limit,
        output ready
    );
endinterface

// ----- rtl/core/dsmu_dir_if.sv -----
// ---------------------------------------------------------------------------
// dsmu_dir_if
// output channel: one sampled direction per transaction
// ---------------------------------------------------------------------------
interface dsmu_dir_if
    import dsmu_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] dir_x;
    logic signed [OUT_W-1:0] dir_y;
    logic signed [OUT_W-1:0] dir_z;

    modport source (
        output valid, dir_x, dir_y, dir_z,
        input  ready
    );

    modport sink (
        input  valid, dir_x, dir_y, dir_z,
        output ready
    );
endinterface

// ----- rtl/core/dsmu_sqrt_cell.sv -----
// ---------------------------------------------------------------------------
// dsmu_sqrt_cell
// one digit of a restoring square root: two argument bits in, one root bit out
// ---------------------------------------------------------------------------
module dsmu_sqrt_cell
    import dsmu_pkg::*;
#(
    parameter int AW  = 34,
    parameter int RW  = 19,
    parameter int RTW = 17,
    parameter int SW  = 8
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  step_t          ctl,
    input  logic [AW-1:0]  arg,
    input  logic [RW-1:0]  rem,
    input  logic [RTW-1:0] root,
    input  logic [SW-1:0]  side,
    output logic           vld,
    output logic [AW-1:0]  arg_sh,
    output logic [RW-1:0]  rem_new,
    output logic [RTW-1:0] root_new,
    output logic [SW-1:0]  side_new
);
    logic           vld_reg;
    logic [AW-1:0]  arg_reg, arg_next;
    logic [RW-1:0]  rem_reg, rem_next;
    logic [RTW-1:0] root_reg, root_next;
    logic [SW-1:0]  side_reg;
    logic [RW+1:0]  rem_cat;
    logic [RW+1:0]  trial;
    logic [RW+1:0]  diff;
    logic           take;

    // trial subtract of 4*root+1
    always_comb
    begin
        rem_cat   = {rem, arg[AW-1 -: 2]};
        trial     = {{(RW-RTW){1'b0}}, root, 2'b01};
        take      = (rem_cat >= trial);
        diff      = rem_cat - trial;
        rem_next  = take ? diff[RW-1:0] : rem_cat[RW-1:0];
        root_next = {root[RTW-2:0], take};
        arg_next  = {arg[AW-3:0], 2'b00};
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (ctl.en)
            vld_reg <= ctl.vld;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            arg_reg  <= arg_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side;
        end
    end

    assign vld      = vld_reg;
    assign arg_sh   = arg_reg;
    assign rem_new  = rem_reg;
    assign root_new = root_reg;
    assign side_new = side_reg;
endmodule

// ----- rtl/core/dsmu_cordic_cell.sv -----
// ---------------------------------------------------------------------------
// dsmu_cordic_cell
// one rotation step of a cordic in rotation mode, angle in binary turns
// ---------------------------------------------------------------------------
module dsmu_cordic_cell
    import dsmu_pkg::*;
#(
    parameter int IDX = 0,
    parameter int SW  = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  step_t                ctl,
    input  logic signed [CW-1:0] cx,
    input  logic signed [CW-1:0] cy,
    input  logic signed [CW-1:0] ca,
    input  logic [SW-1:0]        side,
    output logic                 vld,
    output logic signed [CW-1:0] nx,
    output logic signed [CW-1:0] ny,
    output logic signed [CW-1:0] na,
    output logic [SW-1:0]        side_new
);
    localparam logic signed [CW-1:0] ATAN = $signed(atan_turns(IDX));

    logic                 vld_reg;
    logic signed [CW-1:0] x_reg, x_next;
    logic signed [CW-1:0] y_reg, y_next;
    logic signed [CW-1:0] a_reg, a_next;
    logic [SW-1:0]        side_reg;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    // rotate towards zero residual angle
    always_comb
    begin
        dx = cy >>> IDX;
        dy = cx >>> IDX;
        if (!ca[CW-1])
        begin
            x_next = cx - dx;
            y_next = cy + dy;
            a_next = ca - ATAN;
        end
        else
        begin
            x_next = cx + dx;
            y_next = cy - dy;
            a_next = ca + ATAN;
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (ctl.en)
            vld_reg <= ctl.vld;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            a_reg    <= a_next;
            side_reg <= side;
        end
    end

    assign vld      = vld_reg;
    assign nx       = x_reg;
    assign ny       = y_reg;
    assign na       = a_reg;
    assign side_new = side_reg;
endmodule

// ----- rtl/core/direction_sample_mapper_unit.sv -----
// ---------------------------------------------------------------------------
// direction_sample_mapper_unit
// maps two uniform numbers to a hemisphere, sphere, disk, cosine or cone
// direction
// ---------------------------------------------------------------------------
// usage
//   samples: one transaction per sample (func, first_uniform, second_uniform,
//            cone_cos_limit); taken when valid and ready are both high
//   dirs:    one transaction per sample, dir_x, dir_y, dir_z in q16, in order
//   path:    from acceptance to dirs.valid a sample passes the two chains of
//            square root cells (one root bit each) and the chain of cordic
//            cells (one rotation each)
//   throughput: one sample per cycle while ready is high, every stage has its own registers
//   stall: the whole pipeline advances together; a result that the sink
//          does not take stays in the output register, the next one goes
//          into a skid register, and only when that is full does ready drop
//   reset: rst_n clears all valid bits at once, no clearing pass; ready is
//          high from the first cycle after reset
//   unused func codes give an all-zero direction
// ---------------------------------------------------------------------------
`include "direction_sample_mapper_unit_assert.svh"

module direction_sample_mapper_unit
    import dsmu_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF,
    parameter int FRACTION_BITS    = FRACTION_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    dsmu_sample_if.sink   samples,
    dsmu_dir_if.source    dirs
);
    localparam int F    = FRACTION_BITS;
    localparam int N    = ANGLE_ITERATIONS;
    localparam int ZW   = F + 3;
    localparam int AW   = 2 * F + 2;
    localparam int RW   = F + 3;
    localparam int RTW  = F + 1;
    localparam int XW   = F + 3;
    localparam int WW   = F + 20;
    localparam int LSH  = (F >= IN_W) ? F - IN_W : 0;
    localparam int RSH  = (F < IN_W) ? IN_W - F : 0;
    localparam int OLSH = (F < IN_W) ? IN_W - F : 0;
    localparam int ORSH = (F > IN_W) ? F - IN_W : 0;
    localparam longint ORND = (F > IN_W) ? (64'sd1 <<< (F - IN_W - 1)) : 64'sd0;
    localparam int S1W  = FUNC_W + ZW + IN_W;
    localparam int S2W  = FUNC_W + ZW + RTW + 2;
    localparam int S3W  = FUNC_W + ZW + 2 * XW;

    localparam logic signed [ZW-1:0]    ONE_Z  = ZW'(64'sd1 <<< F);
    localparam logic signed [2*ZW:0]    ONE2_Z = (2*ZW+1)'(64'sd1 <<< (2 * F));
    localparam logic signed [2*XW+1:0]  ONE2_X = (2*XW+2)'(64'sd1 <<< (2 * F));

    // global advance and output buffering
    logic                    en;
    logic                    emit;
    logic                    out_vld_reg;
    logic                    skid_vld_reg;
    logic signed [OUT_W-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic signed [OUT_W-1:0] skid_x_reg, skid_y_reg, skid_z_reg;

    assign en = !skid_vld_reg;

    // input stage: bring u1 and the cone limit to qf
    logic              v0_reg;
    logic [FUNC_W-1:0] f0_reg;
    logic [F-1:0]      u10_reg;
    logic signed [ZW-1:0] cm0_reg;
    logic [IN_W-1:0]   u20_reg;
    logic signed [WW-1:0] u1_w, cm_w;

    always_comb
    begin
        u1_w = ($signed({{(WW-IN_W){1'b0}}, samples.first_uniform}) <<< LSH) >>> RSH;
        cm_w = ($signed({{(WW-OUT_W){samples.cone_cos_limit[OUT_W-1]}},
                samples.cone_cos_limit}) <<< LSH) >>> RSH;
    end

    // z of the hemisphere, sphere and cone mappings, zero for the others
    logic              v1_reg;
    logic [FUNC_W-1:0] f1_reg;
    logic [F-1:0]      u11_reg;
    logic signed [ZW-1:0] z1_reg, z1_next;
    logic [IN_W-1:0]   u21_reg;
    logic signed [ZW-1:0]   cm_d;
    logic signed [2*ZW-1:0] cone_p;
    logic signed [2*ZW-1:0] cone_s;

    always_comb
    begin
        cm_d   = cm0_reg - ONE_Z;
        cone_p = $signed({{(ZW-F){1'b0}}, u10_reg}) * cm_d;
        cone_s = cone_p >>> F;
        priority if (f0_reg == FUNC_HEMI)
            z1_next = $signed({{(ZW-F){1'b0}}, u10_reg});
        else if (f0_reg == FUNC_SPHERE)
            z1_next = ONE_Z - $signed({{(ZW-F-1){1'b0}}, u10_reg, 1'b0});
        else if (f0_reg == FUNC_CONE)
            z1_next = ONE_Z + cone_s[ZW-1:0];
        else
            z1_next = '0;
    end

    // square root argument: u1 for disk and cosine, else 1 - z*z clamped at zero
    logic              v2_reg;
    logic [AW-1:0]     a2_reg, a2_next;
    logic [S1W-1:0]    sd2_reg;
    logic signed [2*ZW-1:0] zz;
    logic signed [2*ZW:0]   zdiff;

    always_comb
    begin
        zz    = z1_reg * z1_reg;
        zdiff = ONE2_Z - {zz[2*ZW-1], zz};
        if (f1_reg == FUNC_DISK || f1_reg == FUNC_COSINE)
            a2_next = {{(AW-2*F){1'b0}}, u11_reg, {F{1'b0}}};
        else if (zdiff[2*ZW] || zdiff == '0)
            a2_next = '0;
        else
            a2_next = zdiff[AW-1:0];
    end

    // input, z and argument stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= samples.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f0_reg  <= samples.func;
            u10_reg <= u1_w[F-1:0];
            cm0_reg <= cm_w[ZW-1:0];
            u20_reg <= samples.second_uniform;
            f1_reg  <= f0_reg;
            u11_reg <= u10_reg;
            z1_reg  <= z1_next;
            u21_reg <= u20_reg;
            a2_reg  <= a2_next;
            sd2_reg <= {f1_reg, z1_reg, u21_reg};
        end
    end

    // first square root chain: radius
    logic           sa_vld  [0:RTW];
    logic [AW-1:0]  sa_arg  [0:RTW];
    logic [RW-1:0]  sa_rem  [0:RTW];
    logic [RTW-1:0] sa_root [0:RTW];
    logic [S1W-1:0] sa_side [0:RTW];

    assign sa_vld[0]  = v2_reg;
    assign sa_arg[0]  = a2_reg;
    assign sa_rem[0]  = '0;
    assign sa_root[0] = '0;
    assign sa_side[0] = sd2_reg;

    for (genvar k = 0; k < RTW; k++)
    begin : g_sqrt_a
        dsmu_sqrt_cell #(.AW(AW), .RW(RW), .RTW(RTW), .SW(S1W)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      ('{en: en, vld: sa_vld[k]}),
            .arg      (sa_arg[k]),
            .rem      (sa_rem[k]),
            .root     (sa_root[k]),
            .side     (sa_side[k]),
            .vld      (sa_vld[k+1]),
            .arg_sh   (sa_arg[k+1]),
            .rem_new  (sa_rem[k+1]),
            .root_new (sa_root[k+1]),
            .side_new (sa_side[k+1])
        );
    end

    // cordic chain: cos and sin of the angle within its quadrant
    logic                 cd_vld  [0:N];
    logic signed [CW-1:0] cd_x    [0:N];
    logic signed [CW-1:0] cd_y    [0:N];
    logic signed [CW-1:0] cd_a    [0:N];
    logic [S2W-1:0]       cd_side [0:N];
    logic [IN_W-1:0]      sa_u2;

    assign sa_u2      = sa_side[RTW][IN_W-1:0];
    assign cd_vld[0]  = sa_vld[RTW];
    assign cd_x[0]    = CORDIC_GAIN_Q30;
    assign cd_y[0]    = '0;
    assign cd_a[0]    = $signed({2'b00, sa_u2[IN_W-3:0], {(CW-IN_W){1'b0}}});
    assign cd_side[0] = {sa_side[RTW][S1W-1:IN_W], sa_root[RTW], sa_u2[IN_W-1 -: 2]};

    for (genvar k = 0; k < N; k++)
    begin : g_cordic
        dsmu_cordic_cell #(.IDX(k), .SW(S2W)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      ('{en: en, vld: cd_vld[k]}),
            .cx       (cd_x[k]),
            .cy       (cd_y[k]),
            .ca       (cd_a[k]),
            .side     (cd_side[k]),
            .vld      (cd_vld[k+1]),
            .nx       (cd_x[k+1]),
            .ny       (cd_y[k+1]),
            .na       (cd_a[k+1]),
            .side_new (cd_side[k+1])
        );
    end

    // quadrant fold
    logic                 vq_reg;
    logic signed [CW-1:0] cq_reg, sq_reg, cq_next, sq_next;
    logic [S2W-3:0]       sdq_reg;
    logic [1:0]           quad;

    always_comb
    begin
        quad = cd_side[N][1:0];
        unique case (quad)
            2'd0:
            begin
                cq_next = cd_x[N];
                sq_next = cd_y[N];
            end
            2'd1:
            begin
                cq_next = -cd_y[N];
                sq_next = cd_x[N];
            end
            2'd2:
            begin
                cq_next = -cd_x[N];
                sq_next = -cd_y[N];
            end
            default:
            begin
                cq_next = cd_y[N];
                sq_next = -cd_x[N];
            end
        endcase
    end

    // scale by the radius
    logic                  vm_reg;
    logic signed [XW-1:0]  xm_reg, ym_reg;
    logic [FUNC_W+ZW-1:0]  sdm_reg;
    logic signed [RTW:0]   r_s;
    logic signed [CW+RTW:0] px, py;
    logic signed [CW+RTW:0] pxs, pys;

    always_comb
    begin
        r_s = $signed({1'b0, sdq_reg[RTW-1:0]});
        px  = cq_reg * r_s;
        py  = sq_reg * r_s;
        pxs = px >>> 30;
        pys = py >>> 30;
    end

    // squares of x and y for the cosine lift
    logic                   vs_reg;
    logic signed [2*XW-1:0] xx_reg, yy_reg;
    logic [S3W-1:0]         sds_reg;

    // lift argument, clamped at zero
    logic                   vl_reg;
    logic [AW-1:0]          al_reg, al_next;
    logic [S3W-1:0]         sdl_reg;
    logic signed [2*XW+1:0] ldiff;

    always_comb
    begin
        ldiff = ONE2_X - {{2{xx_reg[2*XW-1]}}, xx_reg} - {{2{yy_reg[2*XW-1]}}, yy_reg};
        if (ldiff[2*XW+1] || ldiff == '0)
            al_next = '0;
        else
            al_next = ldiff[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vq_reg <= 1'b0;
            vm_reg <= 1'b0;
            vs_reg <= 1'b0;
            vl_reg <= 1'b0;
        end
        else if (en)
        begin
            vq_reg <= cd_vld[N];
            vm_reg <= vq_reg;
            vs_reg <= vm_reg;
            vl_reg <= vs_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cq_reg  <= cq_next;
            sq_reg  <= sq_next;
            sdq_reg <= cd_side[N][S2W-1:2];
            xm_reg  <= pxs[XW-1:0];
            ym_reg  <= pys[XW-1:0];
            sdm_reg <= sdq_reg[S2W-3:RTW];
            xx_reg  <= xm_reg * xm_reg;
            yy_reg  <= ym_reg * ym_reg;
            sds_reg <= {sdm_reg, xm_reg, ym_reg};
            al_reg  <= al_next;
            sdl_reg <= sds_reg;
        end
    end

    // second square root chain: z of the cosine mapping
    logic           sb_vld  [0:RTW];
    logic [AW-1:0]  sb_arg  [0:RTW];
    logic [RW-1:0]  sb_rem  [0:RTW];
    logic [RTW-1:0] sb_root [0:RTW];
    logic [S3W-1:0] sb_side [0:RTW];

    assign sb_vld[0]  = vl_reg;
    assign sb_arg[0]  = al_reg;
    assign sb_rem[0]  = '0;
    assign sb_root[0] = '0;
    assign sb_side[0] = sdl_reg;

    for (genvar k = 0; k < RTW; k++)
    begin : g_sqrt_b
        dsmu_sqrt_cell #(.AW(AW), .RW(RW), .RTW(RTW), .SW(S3W)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      ('{en: en, vld: sb_vld[k]}),
            .arg      (sb_arg[k]),
            .rem      (sb_rem[k]),
            .root     (sb_root[k]),
            .side     (sb_side[k]),
            .vld      (sb_vld[k+1]),
            .arg_sh   (sb_arg[k+1]),
            .rem_new  (sb_rem[k+1]),
            .root_new (sb_root[k+1]),
            .side_new (sb_side[k+1])
        );
    end

    // qf to q16 with rounding and saturation
    function automatic logic signed [OUT_W-1:0] to_q16(input logic signed [47:0] v);
        logic signed [63:0] q;
        logic signed [OUT_W-1:0] res;
        q = ((64'(v) + ORND) >>> ORSH) <<< OLSH;
        if (q > 64'sd131071)
            res = 18'sd131071;
        else if (q < -64'sd131072)
            res = -18'sd131072;
        else
            res = q[OUT_W-1:0];
        return res;
    endfunction

    // final selection of z and conversion
    logic                    ve_reg;
    logic signed [OUT_W-1:0] xe_reg, ye_reg, ze_reg;
    logic signed [OUT_W-1:0] xe_next, ye_next, ze_next;
    logic [FUNC_W-1:0]       fe;
    logic signed [ZW-1:0]    ze;
    logic signed [XW-1:0]    xe, ye;
    logic signed [ZW-1:0]    zsel;

    always_comb
    begin
        fe = sb_side[RTW][S3W-1 -: FUNC_W];
        ze = sb_side[RTW][2*XW +: ZW];
        xe = sb_side[RTW][XW +: XW];
        ye = sb_side[RTW][XW-1:0];
        priority if (fe == FUNC_DISK)
            zsel = '0;
        else if (fe == FUNC_COSINE)
            zsel = $signed({{(ZW-RTW){1'b0}}, sb_root[RTW]});
        else
            zsel = ze;
        if (fe == FUNC_HEMI || fe == FUNC_SPHERE || fe == FUNC_DISK
            || fe == FUNC_COSINE || fe == FUNC_CONE)
        begin
            xe_next = to_q16({{(48-XW){xe[XW-1]}}, xe});
            ye_next = to_q16({{(48-XW){ye[XW-1]}}, ye});
            ze_next = to_q16({{(48-ZW){zsel[ZW-1]}}, zsel});
        end
        else
        begin
            xe_next = '0;
            ye_next = '0;
            ze_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ve_reg <= 1'b0;
        else if (en)
            ve_reg <= sb_vld[RTW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xe_reg <= xe_next;
            ye_reg <= ye_next;
            ze_reg <= ze_next;
        end
    end

    // output register and skid register
    assign emit = en && ve_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || dirs.ready)
        begin
            out_vld_reg  <= skid_vld_reg || emit;
            skid_vld_reg <= 1'b0;
        end
        else if (emit)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || dirs.ready)
        begin
            if (skid_vld_reg)
            begin
                out_x_reg <= skid_x_reg;
                out_y_reg <= skid_y_reg;
                out_z_reg <= skid_z_reg;
            end
            else
            begin
                out_x_reg <= xe_reg;
                out_y_reg <= ye_reg;
                out_z_reg <= ze_reg;
            end
        end
        else if (emit)
        begin
            skid_x_reg <= xe_reg;
            skid_y_reg <= ye_reg;
            skid_z_reg <= ze_reg;
        end
    end

    assign samples.ready = en;
    assign dirs.valid    = out_vld_reg;
    assign dirs.dir_x    = out_x_reg;
    assign dirs.dir_y    = out_y_reg;
    assign dirs.dir_z    = out_z_reg;

    // checks on the output buffering
    `DSMU_ASSERT_IMP(a_skid_behind_out, skid_vld_reg, out_vld_reg, "skid full, output empty")
    `DSMU_ASSERT(a_skid_keeps_out, skid_vld_reg |=> out_vld_reg, "output lost after skid")
    `DSMU_ASSERT_IMP(a_skid_drains, $fell(skid_vld_reg), $past(dirs.valid && dirs.ready),
        "skid drained without a transaction")
    `DSMU_ASSERT(a_held_fills_skid, (out_vld_reg && !dirs.ready && emit) |=> skid_vld_reg,
        "result dropped while output held")
endmodule

// ----- tb/direction_sample_mapper_unit_tb.sv -----
// ---------------------------------------------------------------------------
// direction sample mapper testbench
// drives bursts of samples over every mapping, checks each direction against
// a fixed-point predictor, with random gaps, receiver stalls and a long hold
// ---------------------------------------------------------------------------

// expected directions, oldest first
class direction_scoreboard;
    typedef struct {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [17:0] z;
    } dir_t;

    dir_t pending[$];
    int   errors;

    static function longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    static function longint isqrt(longint arg);
        longint a;
        longint res;
        longint bitv;
        if (arg <= 0)
            return 0;
        a    = arg;
        res  = 0;
        bitv = 64'sd1 << 62;
        while (bitv > a)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (a >= res + bitv)
            begin
                a   = a - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // cordic rotation of the angle within its quadrant, quadrant fixed after
    static function void rotate(logic [15:0] t, output longint c, output longint s);
        longint cx;
        longint cy;
        longint ang;
        longint dx;
        longint dy;
        cx  = 652032874;
        cy  = 0;
        ang = longint'(t[13:0]) << 16;
        for (int i = 0; i < 16; i++)
        begin
            dx = floor_shr(cy, i);
            dy = floor_shr(cx, i);
            if (ang >= 0)
            begin
                cx  = cx - dx;
                cy  = cy + dy;
                ang = ang - longint'(dsmu_pkg::atan_turns(i));
            end
            else
            begin
                cx  = cx + dx;
                cy  = cy - dy;
                ang = ang + longint'(dsmu_pkg::atan_turns(i));
            end
        end
        case (t[15:14])
            2'd0:    begin c = cx;  s = cy;  end
            2'd1:    begin c = -cy; s = cx;  end
            2'd2:    begin c = -cx; s = -cy; end
            default: begin c = cy;  s = -cx; end
        endcase
    endfunction

    static function logic signed [17:0] sat18(longint v);
        if (v > 131071)
            return 18'sd131071;
        if (v < -131072)
            return -18'sd131072;
        return v[17:0];
    endfunction

    function void note_sample(logic [2:0] func, logic [15:0] u1_in, logic [15:0] u2,
                              logic signed [17:0] cone);
        longint one;
        longint u1;
        longint cm;
        longint r;
        longint z;
        longint c;
        longint s;
        longint x;
        longint y;
        dir_t   d;
        one = 64'sd1 << 16;
        u1  = longint'(u1_in);
        cm  = longint'(cone);
        z   = 0;
        r   = 0;
        if (func > dsmu_pkg::FUNC_CONE)
        begin
            d.x = 0;
            d.y = 0;
            d.z = 0;
            pending.push_back(d);
            return;
        end
        case (func)
            dsmu_pkg::FUNC_HEMI:
            begin
                z = u1;
                r = isqrt(one * one - z * z);
            end
            dsmu_pkg::FUNC_SPHERE:
            begin
                z = one - 2 * u1;
                r = isqrt(one * one - z * z);
            end
            dsmu_pkg::FUNC_DISK, dsmu_pkg::FUNC_COSINE:
                r = isqrt(u1 * one);
            default:
            begin
                z = one + floor_shr(u1 * (cm - one), 16);
                r = isqrt(one * one - z * z);
            end
        endcase
        rotate(u2, c, s);
        x = floor_shr(c * r, 30);
        y = floor_shr(s * r, 30);
        if (func == dsmu_pkg::FUNC_DISK)
            z = 0;
        else if (func == dsmu_pkg::FUNC_COSINE)
            z = isqrt(one * one - x * x - y * y);
        d.x = sat18(x);
        d.y = sat18(y);
        d.z = sat18(z);
        pending.push_back(d);
    endfunction

    function void check_dir(logic signed [17:0] x, logic signed [17:0] y,
                            logic signed [17:0] z);
        dir_t d;
        if (pending.size() == 0)
        begin
            $error("direction with no sample waiting");
            errors++;
            return;
        end
        d = pending.pop_front();
        if (x !== d.x)
        begin
            $error("dir_x expected %0d actual %0d", d.x, x);
            errors++;
        end
        if (y !== d.y)
        begin
            $error("dir_y expected %0d actual %0d", d.y, y);
            errors++;
        end
        if (z !== d.z)
        begin
            $error("dir_z expected %0d actual %0d", d.z, z);
            errors++;
        end
    endfunction
endclass

module tb;
    import dsmu_pkg::*;

    localparam int LATENCY    = 2 * FRACTION_BITS_DEF + ANGLE_ITERATIONS_DEF + 11;
    localparam int IDLE_LIMIT = 20000;
    localparam int N_RANDOM   = 1800;

    logic clk;
    logic rst_n;
    logic stim_done;
    logic hold_off;
    int   idle_cycles;

    direction_scoreboard sb;

    dsmu_sample_if samples ();
    dsmu_dir_if    dirs ();

    direction_sample_mapper_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples.sink),
        .dirs    (dirs.source)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // one sample transaction, held until accepted
    task automatic send_sample(logic [2:0] func, logic [15:0] u1, logic [15:0] u2,
                               logic signed [17:0] cone);
        samples.valid          <= 1'b1;
        samples.func           <= func;
        samples.first_uniform  <= u1;
        samples.second_uniform <= u2;
        samples.cone_cos_limit <= cone;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
    endtask

    task automatic send_gap(int n);
        samples.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // random sample, cone limit mostly within [-1, 1]
    task automatic send_random();
        logic [2:0]         f;
        logic signed [17:0] cone;
        f = (($urandom_range(0, 19)) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
        if ($urandom_range(0, 9) == 0)
            cone = 18'($urandom);
        else
            cone = 18'($signed($urandom_range(0, 131072)) - 65536);
        send_sample(f, 16'($urandom), 16'($urandom), cone);
    endtask

    // stimulus
    initial
    begin
        samples.valid          = 1'b0;
        samples.func           = '0;
        samples.first_uniform  = '0;
        samples.second_uniform = '0;
        samples.cone_cos_limit = '0;
        stim_done              = 1'b0;
        rst_n                  = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes of every mapping, unused codes, odd cone limits
        for (int f = 0; f <= 4; f++)
        begin
            send_sample(3'(f), 16'h0000, 16'h0000, 18'sd65536);
            send_sample(3'(f), 16'hFFFF, 16'hFFFF, -18'sd65536);
            send_sample(3'(f), 16'h8000, 16'h4000, 18'sd0);
        end
        send_sample(3'd5, 16'hFFFF, 16'hFFFF, 18'sd1);
        send_sample(3'd6, 16'h1234, 16'h8000, -18'sd1);
        send_sample(3'd7, 16'hFFFF, 16'hC000, 18'sd131071);
        send_sample(FUNC_CONE, 16'hFFFF, 16'h2000, 18'sd131071);
        send_sample(FUNC_CONE, 16'hFFFF, 16'h6000, -18'sd131072);
        send_sample(FUNC_CONE, 16'h8000, 16'hA000, 18'sd100000);
        send_gap(3);

        // random bursts with gaps, some bursts back to back
        for (int n = 0; n < N_RANDOM; )
        begin
            int burst;
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n < N_RANDOM; k++, n++)
                send_random();
            if ($urandom_range(0, 3) != 0)
                send_gap($urandom_range(1, 8));
        end
        samples.valid <= 1'b0;
        stim_done     <= 1'b1;
    end

    // receiver stall pattern, one long hold early on
    initial
    begin
        hold_off = 1'b0;
        @(posedge rst_n);
        repeat (30) @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        int mode;
        mode = ($urandom_range(0, 999) < 500) ? 0 : 1;
        if (!rst_n || hold_off)
            dirs.ready <= 1'b0;
        else if ((($urandom_range(0, 255)) & 8'hC0) == 0)
            dirs.ready <= 1'b1;
        else
            dirs.ready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end

    // scoreboard feed and watchdog
    initial
        sb = new();

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (samples.valid && samples.ready)
                sb.note_sample(samples.func, samples.first_uniform,
                               samples.second_uniform, samples.cone_cos_limit);
            if (dirs.valid && dirs.ready)
                sb.check_dir(dirs.dir_x, dirs.dir_y, dirs.dir_z);
            if ((samples.valid && samples.ready) || (dirs.valid && dirs.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            // nothing moving for too long, stop whatever the stimulus is doing
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
        else
            idle_cycles <= 0;
    end

    // end of run
    initial
    begin
        @(posedge stim_done);
        while (sb.pending.size() != 0 && idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            repeat (LATENCY + 10) @(posedge clk);
            if (sb.errors == 0 && sb.pending.size() == 0)
                $display("Simulation PASSED");
            else
                $display("Simulation FAILED");
            $finish;
        end
    end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/dsmu_pkg.sv
rtl/core/dsmu_sample_if.sv
rtl/core/dsmu_dir_if.sv
rtl/core/dsmu_sqrt_cell.sv
rtl/core/dsmu_cordic_cell.sv
rtl/core/direction_sample_mapper_unit.sv
tb/direction_sample_mapper_unit_tb.sv
